FILE: hdl/tmass_pkg.sv
// Shared constants for the transverse mass block.
package tmass_pkg;

    // Fixed field widths
    localparam int MASS_BITS     = 16;
    localparam int OUT_BITS      = 19;
    localparam int OUT_DATA_BITS = 24;

    // Output saturation limits (positive limit and magnitude of negative limit)
    localparam int OUT_MAX       = 262143;
    localparam int OUT_MIN_MAG   = 262144;

    // Operation codes
    localparam logic OP_TWO_BODY  = 1'b0;
    localparam logic OP_FOUR_BODY = 1'b1;

endpackage

FILE: hdl/tmass_isqrt.sv
// Pipelined floored integer square root, one result bit per stage, with sideband.
module tmass_isqrt #(
    parameter int NW = 38,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic [NW-1:0] rad,
    input  logic [PW-1:0] pay_in,
    output logic [NW/2-1:0] root,
    output logic [PW-1:0] pay_out
);
    localparam int RW   = NW / 2;
    localparam int REMW = RW + 3;

    logic [REMW-1:0] rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [NW-1:0]   rad_reg  [RW];
    logic [PW-1:0]   pay_reg  [RW];

    generate
        for (genvar k = 0; k < RW; k++) begin : g_stage
            logic [REMW-1:0] rem_in;
            logic [RW-1:0]   root_in;
            logic [NW-1:0]   rad_in;
            logic [PW-1:0]   pay_k;
            logic [REMW-1:0] t;
            logic [REMW-1:0] trial;

            if (k == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = rad;
                assign pay_k   = pay_in;
            end else begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign rad_in  = rad_reg[k-1];
                assign pay_k   = pay_reg[k-1];
            end

            // Bring down the next two radicand bits and try the next root bit
            assign t     = {rem_in[REMW-3:0], rad_in[NW-1 -: 2]};
            assign trial = REMW'({root_in, 2'b01});

            // Hold sideband through the stage; reset clears it (carries valid)
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    pay_reg[k] <= '0;
                end else if (en) begin
                    pay_reg[k] <= pay_k;
                end
            end

            // Advance remainder, partial root and remaining radicand
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k] <= rad_in << 2;
                    if (t >= trial) begin
                        rem_reg[k]  <= t - trial;
                        root_reg[k] <= {root_in[RW-2:0], 1'b1};
                    end else begin
                        rem_reg[k]  <= t;
                        root_reg[k] <= {root_in[RW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign root    = root_reg[RW-1];
    assign pay_out = pay_reg[RW-1];

endmodule

FILE: hdl/tmass_kernel.sv
// Pipelined two-body signed transverse mass: magnitude and sign of the result.
module tmass_kernel #(
    parameter int CW = 16,
    parameter int MW = 16,
    parameter int PW = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic signed [CW-1:0] px,
    input  logic signed [CW-1:0] py,
    input  logic signed [CW-1:0] qx,
    input  logic signed [CW-1:0] qy,
    input  logic [MW-1:0]        mp,
    input  logic [MW-1:0]        mq,
    input  logic [PW-1:0]        pay_in,
    output logic [((CW > MW) ? CW : MW)+1:0] mag,
    output logic                 neg,
    output logic [PW-1:0]        pay_out
);
    localparam int RADW = 2 * ((CW > MW) ? CW : MW) + 2;
    localparam int RTW  = RADW / 2;
    localparam int DW   = RADW + 2;

    // Magnitudes of components and pair sums
    logic signed [CW:0] sx;
    logic signed [CW:0] sy;
    logic [CW-1:0] apx, apy, aqx, aqy;
    logic [CW:0]   asx, asy;

    always_comb begin
        sx  = (CW+1)'(px) + (CW+1)'(qx);
        sy  = (CW+1)'(py) + (CW+1)'(qy);
        apx = px[CW-1] ? CW'(-px) : CW'(px);
        apy = py[CW-1] ? CW'(-py) : CW'(py);
        aqx = qx[CW-1] ? CW'(-qx) : CW'(qx);
        aqy = qy[CW-1] ? CW'(-qy) : CW'(qy);
        asx = sx[CW] ? (CW+1)'(-sx) : (CW+1)'(sx);
        asy = sy[CW] ? (CW+1)'(-sy) : (CW+1)'(sy);
    end

    // Stage 1: squares
    logic [2*CW-1:0] pxx_reg, pyy_reg, qxx_reg, qyy_reg;
    logic [2*CW+1:0] sxx_reg, syy_reg;
    logic [2*MW-1:0] mpp_reg, mqq_reg;
    logic [PW-1:0]   pay1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pxx_reg <= (2*CW)'(apx) * (2*CW)'(apx);
            pyy_reg <= (2*CW)'(apy) * (2*CW)'(apy);
            qxx_reg <= (2*CW)'(aqx) * (2*CW)'(aqx);
            qyy_reg <= (2*CW)'(aqy) * (2*CW)'(aqy);
            sxx_reg <= (2*CW+2)'(asx) * (2*CW+2)'(asx);
            syy_reg <= (2*CW+2)'(asy) * (2*CW+2)'(asy);
            mpp_reg <= (2*MW)'(mp) * (2*MW)'(mp);
            mqq_reg <= (2*MW)'(mq) * (2*MW)'(mq);
        end
    end

    // Stage 2: radicands of both energies and the summed momentum square
    logic [RADW-1:0] rp_reg, rq_reg, s2_reg;
    logic [PW-1:0]   pay2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rp_reg <= RADW'(pxx_reg) + RADW'(pyy_reg) + RADW'(mpp_reg);
            rq_reg <= RADW'(qxx_reg) + RADW'(qyy_reg) + RADW'(mqq_reg);
            s2_reg <= RADW'(sxx_reg) + RADW'(syy_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pay1_reg <= '0;
            pay2_reg <= '0;
        end else if (en) begin
            pay1_reg <= pay_in;
            pay2_reg <= pay1_reg;
        end
    end

    // Energy roots; the momentum square rides along the second root
    logic [RTW-1:0]  ep, eq;
    logic [PW-1:0]   pay_e;
    logic [RADW-1:0] s_e;

    tmass_isqrt #(.NW(RADW), .PW(PW)) u_root_p (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .rad     (rp_reg),
        .pay_in  (pay2_reg),
        .root    (ep),
        .pay_out (pay_e)
    );

    tmass_isqrt #(.NW(RADW), .PW(RADW)) u_root_q (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .rad     (rq_reg),
        .pay_in  (s2_reg),
        .root    (eq),
        .pay_out (s_e)
    );

    // Stages 3 to 5: total energy, its square, signed difference
    logic [RTW:0]    et_reg;
    logic [DW-1:0]   et2_reg;
    logic [RADW-1:0] s3_reg, s4_reg;
    logic [DW-1:0]   diff_reg;
    logic            neg5_reg;
    logic [PW-1:0]   pay3_reg, pay4_reg, pay5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            et_reg  <= (RTW+1)'(ep) + (RTW+1)'(eq);
            s3_reg  <= s_e;
            et2_reg <= DW'(et_reg) * DW'(et_reg);
            s4_reg  <= s3_reg;
            if (et2_reg > DW'(s4_reg)) begin
                neg5_reg <= 1'b0;
                diff_reg <= et2_reg - DW'(s4_reg);
            end else begin
                neg5_reg <= 1'b1;
                diff_reg <= DW'(s4_reg) - et2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pay3_reg <= '0;
            pay4_reg <= '0;
            pay5_reg <= '0;
        end else if (en) begin
            pay3_reg <= pay_e;
            pay4_reg <= pay3_reg;
            pay5_reg <= pay4_reg;
        end
    end

    // Final root of the difference, sign carried alongside
    tmass_isqrt #(.NW(DW), .PW(PW+1)) u_root_m (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .rad     (diff_reg),
        .pay_in  ({neg5_reg, pay5_reg}),
        .root    (mag),
        .pay_out ({neg, pay_out})
    );

endmodule

FILE: hdl/tmass_front.sv
// Input side: unpack, form pair sums by opcode and queue items for the datapath.
module tmass_front #(
    parameter int MOMENTUM_BITS = 16,
    parameter int DATA_BITS     = 168,
    parameter int ENTRY_BITS    = 197
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_BITS-1:0]  s_tdata,
    output logic                  head_valid,
    input  logic                  head_pop,
    output logic [ENTRY_BITS-1:0] head_data
);
    localparam int M     = MOMENTUM_BITS;
    localparam int MB    = tmass_pkg::MASS_BITS;
    localparam int DEPTH = 4;
    localparam int PTRW  = $clog2(DEPTH);

    logic                op;
    logic signed [M-1:0] a_px, a_py, b_px, b_py, c_px, c_py, d_px, d_py;
    logic [MB-1:0]       mass_a, mass_b;
    logic signed [M:0]   p_x, p_y, q_x, q_y;

    // Unpack and classify: four-body sums pairs, two-body takes A and B as is
    always_comb begin
        op     = s_tdata[0];
        a_px   = s_tdata[1 + 0*M +: M];
        a_py   = s_tdata[1 + 1*M +: M];
        b_px   = s_tdata[1 + 2*M +: M];
        b_py   = s_tdata[1 + 3*M +: M];
        c_px   = s_tdata[1 + 4*M +: M];
        c_py   = s_tdata[1 + 5*M +: M];
        d_px   = s_tdata[1 + 6*M +: M];
        d_py   = s_tdata[1 + 7*M +: M];
        mass_a = s_tdata[1 + 8*M +: MB];
        mass_b = s_tdata[1 + 8*M + MB +: MB];
        if (op == tmass_pkg::OP_FOUR_BODY) begin
            p_x = (M+1)'(a_px) + (M+1)'(b_px);
            p_y = (M+1)'(a_py) + (M+1)'(b_py);
            q_x = (M+1)'(c_px) + (M+1)'(d_px);
            q_y = (M+1)'(c_py) + (M+1)'(d_py);
        end else begin
            p_x = (M+1)'(a_px);
            p_y = (M+1)'(a_py);
            q_x = (M+1)'(b_px);
            q_y = (M+1)'(b_py);
        end
    end

    // Item queue
    logic [ENTRY_BITS-1:0] mem_reg [DEPTH];
    logic [PTRW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [PTRW:0]         count_reg;
    logic                  push;

    assign s_tready   = (count_reg != (PTRW+1)'(DEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= {mass_b, mass_a, q_y, q_x, p_y, p_x,
                                    d_py, d_px, c_py, c_px, b_py, b_px, a_py, a_px, op};
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (head_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !head_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && head_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/tmass_back.sv
// Datapath: pair masses, final two-body kernel, saturation and output register.
module tmass_back #(
    parameter int MOMENTUM_BITS = 16,
    parameter int ENTRY_BITS    = 197
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    output logic                  head_pop,
    input  logic [ENTRY_BITS-1:0] head_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [tmass_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    localparam int M    = MOMENTUM_BITS;
    localparam int MB   = tmass_pkg::MASS_BITS;
    localparam int OB   = tmass_pkg::OUT_BITS;
    localparam int MAG1 = M + 2;
    localparam int MW2  = (M + 2 > MB) ? M + 2 : MB;
    localparam int MAG2 = ((M + 1 > MW2) ? M + 1 : MW2) + 2;
    localparam int PW1  = 1 + 4*(M+1) + 2*MB;

    logic                en;
    logic                op;
    logic signed [M-1:0] a_px, a_py, b_px, b_py, c_px, c_py, d_px, d_py;
    logic signed [M:0]   p_x, p_y, q_x, q_y;
    logic [MB-1:0]       mass_a, mass_b;

    // Whole pipeline advances unless a finished item waits at the output
    assign en       = !m_tvalid || m_tready;
    assign head_pop = en && head_valid;

    assign {mass_b, mass_a, q_y, q_x, p_y, p_x,
            d_py, d_px, c_py, c_px, b_py, b_px, a_py, a_px, op} = head_data;

    // Level 1: massless pair masses of AB and CD
    logic [MAG1-1:0] mab, mcd;
    logic            nab, ncd;
    logic [PW1-1:0]  pay_ab;
    logic            op1;
    logic            v1;
    logic signed [M:0] p1_x, p1_y, q1_x, q1_y;
    logic [MB-1:0]   ma1, mb1;

    tmass_kernel #(.CW(M), .MW(1), .PW(PW1)) u_pair_ab (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .px      (a_px),
        .py      (a_py),
        .qx      (b_px),
        .qy      (b_py),
        .mp      (1'b0),
        .mq      (1'b0),
        .pay_in  ({head_valid, p_x, p_y, q_x, q_y, mass_a, mass_b}),
        .mag     (mab),
        .neg     (nab),
        .pay_out (pay_ab)
    );

    tmass_kernel #(.CW(M), .MW(1), .PW(1)) u_pair_cd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .px      (c_px),
        .py      (c_py),
        .qx      (d_px),
        .qy      (d_py),
        .mp      (1'b0),
        .mq      (1'b0),
        .pay_in  (op),
        .mag     (mcd),
        .neg     (ncd),
        .pay_out (op1)
    );

    assign {v1, p1_x, p1_y, q1_x, q1_y, ma1, mb1} = pay_ab;

    // Select masses for the final kernel; only magnitudes matter
    logic [MW2-1:0] mp2, mq2;

    always_comb begin
        if (op1 == tmass_pkg::OP_FOUR_BODY) begin
            mp2 = MW2'(mab) | MW2'({{MAG1{1'b0}}, nab & 1'b0});
            mq2 = MW2'(mcd) | MW2'({{MAG1{1'b0}}, ncd & 1'b0});
        end else begin
            mp2 = MW2'(ma1);
            mq2 = MW2'(mb1);
        end
    end

    // Level 2: final two-body kernel
    logic [MAG2-1:0] mag2;
    logic            neg2;
    logic            v2;

    tmass_kernel #(.CW(M+1), .MW(MW2), .PW(1)) u_final (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .px      (p1_x),
        .py      (p1_y),
        .qx      (q1_x),
        .qy      (q1_y),
        .mp      (mp2),
        .mq      (mq2),
        .pay_in  (v1),
        .mag     (mag2),
        .neg     (neg2),
        .pay_out (v2)
    );

    // Saturate signed result to the output range
    logic [31:0]   mag_w;
    logic [OB-1:0] res;

    always_comb begin
        mag_w = 32'(mag2);
        if (!neg2) begin
            res = (mag_w > 32'(tmass_pkg::OUT_MAX)) ? OB'(tmass_pkg::OUT_MAX) : OB'(mag_w);
        end else begin
            res = (mag_w > 32'(tmass_pkg::OUT_MIN_MAG)) ?
                  OB'(tmass_pkg::OUT_MIN_MAG) : OB'(32'd0 - mag_w);
        end
    end

    // Output register
    logic          m_valid_reg;
    logic [OB-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = tmass_pkg::OUT_DATA_BITS'(m_data_reg);

endmodule

FILE: hdl/transverse_mass_two_and_four_body_top.sv
// Throughput: one item per cycle unless m_tready stalls; every stage is pipelined,
// including the root units, which settle one result bit per stage. A four-entry input
// queue decouples intake. Opcode 0 passes through the pair-mass stage unused, so both
// opcodes share the latency. Reset (aresetn low, synchronous) empties the queue and
// clears all valid flags. Stall on m_tready holds the whole datapath; s_tready drops
// only when the queue is full.
module transverse_mass_two_and_four_body_top #(
    parameter int MOMENTUM_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // opcode, a_px, a_py, b_px, b_py, c_px, c_py, d_px, d_py, mass_a, mass_b (from bit 0)
    input  logic [((1 + 8*MOMENTUM_BITS + 2*tmass_pkg::MASS_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // transverse_mass (from bit 0)
    output logic [tmass_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    localparam int DATA_BITS  = ((1 + 8*MOMENTUM_BITS + 2*tmass_pkg::MASS_BITS + 7) / 8) * 8;
    localparam int ENTRY_BITS = 1 + 8*MOMENTUM_BITS + 4*(MOMENTUM_BITS+1)
                                + 2*tmass_pkg::MASS_BITS;

    logic                  head_valid;
    logic                  head_pop;
    logic [ENTRY_BITS-1:0] head_data;

    tmass_front #(
        .MOMENTUM_BITS (MOMENTUM_BITS),
        .DATA_BITS     (DATA_BITS),
        .ENTRY_BITS    (ENTRY_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_data  (head_data)
    );

    tmass_back #(
        .MOMENTUM_BITS (MOMENTUM_BITS),
        .ENTRY_BITS    (ENTRY_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_data  (head_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: tb/tb_transverse_mass_two_and_four_body_top.sv
// Self-checking testbench for the two- and four-body transverse mass pipeline.
`timescale 1ns / 100ps

module tb_transverse_mass_two_and_four_body_top;

    localparam int MOM_BITS  = 16;
    localparam int IN_BITS   = ((1 + 8*MOM_BITS + 2*tmass_pkg::MASS_BITS + 7) / 8) * 8;
    localparam int WDOG_MAX  = 5000;
    localparam int N_RANDOM  = 1500;

    typedef logic signed [MOM_BITS-1:0] mom_t;
    typedef logic signed [tmass_pkg::OUT_BITS-1:0] tmass_t;
    typedef logic [tmass_pkg::MASS_BITS-1:0] mass_t;

    typedef struct packed {
        mass_t mass_b;
        mass_t mass_a;
        mom_t dy, dx, cy, cx, by, bx, ay, ax;
        logic opcode;
    } event_t;

    // Floored integer square root
    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned sq(longint x);
        longint unsigned m;
        m = (x < 0) ? longint'(-x) : longint'(x);
        return m * m;
    endfunction

    // Signed two-body mass from squared masses
    function automatic longint pair_mass(longint px, longint py, longint qx, longint qy,
                                         longint unsigned mp2, longint unsigned mq2);
        longint unsigned et;
        longint unsigned et2;
        longint unsigned s;
        et  = int_root(sq(px) + sq(py) + mp2) + int_root(sq(qx) + sq(qy) + mq2);
        et2 = et * et;
        s   = sq(px + qx) + sq(py + qy);
        if (et2 > s) return longint'(int_root(et2 - s));
        return -longint'(int_root(s - et2));
    endfunction

    function automatic tmass_t event_mass(event_t e);
        longint ax, ay, bx, by, cx, cy, dx, dy, r, mab, mcd;
        ax = e.ax; ay = e.ay; bx = e.bx; by = e.by;
        cx = e.cx; cy = e.cy; dx = e.dx; dy = e.dy;
        if (e.opcode == tmass_pkg::OP_TWO_BODY) begin
            r = pair_mass(ax, ay, bx, by, sq(longint'(e.mass_a)), sq(longint'(e.mass_b)));
        end else begin
            mab = pair_mass(ax, ay, bx, by, 0, 0);
            mcd = pair_mass(cx, cy, dx, dy, 0, 0);
            r = pair_mass(ax + bx, ay + by, cx + dx, cy + dy, sq(mab), sq(mcd));
        end
        if (r > tmass_pkg::OUT_MAX) r = tmass_pkg::OUT_MAX;
        if (r < -longint'(tmass_pkg::OUT_MIN_MAG)) r = -longint'(tmass_pkg::OUT_MIN_MAG);
        return tmass_t'(r);
    endfunction

    // Expected masses in order of acceptance
    class mass_scoreboard;
        tmass_t pending_mass[$];
        int     n_bad;

        function void note_event(event_t e);
            pending_mass.push_back(event_mass(e));
        endfunction

        function void check_mass(tmass_t got);
            tmass_t want;
            if (pending_mass.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result %0d", got);
                return;
            end
            want = pending_mass.pop_front();
            if (got !== want) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("transverse_mass mismatch: expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_BITS-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [tmass_pkg::OUT_DATA_BITS-1:0] m_tdata;

    mass_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int quiet_cycles;

    transverse_mass_two_and_four_body_top #(.MOMENTUM_BITS(MOM_BITS)) dut (.*);

    // Clock
    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    // Receiver: random stalls, with a long hold-off on request
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each result item
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_mass(tmass_t'(m_tdata[tmass_pkg::OUT_BITS-1:0]));
    end

    // Watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_MAX) begin
            $display("tb_transverse_mass_two_and_four_body_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item, holding it until it is accepted
    task automatic send_event(event_t e);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_BITS'(e);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_event(e);
    endtask

    function automatic mom_t rand_mom(bit narrow);
        if (narrow) return mom_t'($urandom_range(0, 2000) - 1000);
        return mom_t'($urandom);
    endfunction

    function automatic event_t rand_event();
        event_t e;
        bit narrow;
        narrow = 1'($urandom_range(1));
        e.opcode = 1'($urandom_range(1));
        e.ax = rand_mom(narrow); e.ay = rand_mom(narrow);
        e.bx = rand_mom(narrow); e.by = rand_mom(narrow);
        e.cx = rand_mom(narrow); e.cy = rand_mom(narrow);
        e.dx = rand_mom(narrow); e.dy = rand_mom(narrow);
        e.mass_a = narrow ? mass_t'($urandom_range(1000)) : mass_t'($urandom);
        e.mass_b = narrow ? mass_t'($urandom_range(1000)) : mass_t'($urandom);
        return e;
    endfunction

    function automatic event_t make_event(logic op, int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy, int ma, int mb);
        event_t e;
        e.opcode = op;
        e.ax = mom_t'(ax); e.ay = mom_t'(ay); e.bx = mom_t'(bx); e.by = mom_t'(by);
        e.cx = mom_t'(cx); e.cy = mom_t'(cy); e.dx = mom_t'(dx); e.dy = mom_t'(dy);
        e.mass_a = mass_t'(ma); e.mass_b = mass_t'(mb);
        return e;
    endfunction

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zeros, extremes, equal energy and momentum, ignored fields
        send_event(make_event(tmass_pkg::OP_TWO_BODY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_event(make_event(tmass_pkg::OP_FOUR_BODY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_event(make_event(tmass_pkg::OP_TWO_BODY, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0));
        send_event(make_event(tmass_pkg::OP_TWO_BODY, 3, 4, 6, 8, 0, 0, 0, 0, 0, 0));
        send_event(make_event(tmass_pkg::OP_TWO_BODY, 100, 0, -100, 0, -7, 9, 32767, -32768,
                              0, 0));
        send_event(make_event(tmass_pkg::OP_TWO_BODY, 0, 0, 0, 0, 0, 0, 0, 0, 65535, 65535));
        send_event(make_event(tmass_pkg::OP_TWO_BODY, 32767, 32767, 32767, 32767,
                              0, 0, 0, 0, 65535, 65535));
        send_event(make_event(tmass_pkg::OP_TWO_BODY, -32768, -32768, -32768, -32768,
                              -1, -1, -1, -1, 0, 0));
        send_event(make_event(tmass_pkg::OP_TWO_BODY, 32767, -32768, -32768, 32767,
                              0, 0, 0, 0, 65535, 0));
        send_event(make_event(tmass_pkg::OP_FOUR_BODY, 32767, 0, -32768, 0, 0, 32767,
                              0, -32768, 65535, 65535));
        send_event(make_event(tmass_pkg::OP_FOUR_BODY, 32767, 32767, -32768, -32768,
                              -32768, 32767, 32767, -32768, 0, 0));
        send_event(make_event(tmass_pkg::OP_FOUR_BODY, 32767, 32767, 32767, 32767,
                              -32768, -32768, -32768, -32768, 1234, 4321));
        send_event(make_event(tmass_pkg::OP_FOUR_BODY, -32768, 32767, -32768, 32767,
                              32767, -32768, 32767, -32768, 0, 0));
        send_event(make_event(tmass_pkg::OP_FOUR_BODY, 3, 4, 0, 0, -3, -4, 0, 0, 0, 0));
        send_event(make_event(tmass_pkg::OP_FOUR_BODY, 1, 0, 1, 0, 1, 0, 1, 0, 0, 0));

        // Random phases: free flow, idle sender, stalling receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 55 : (ph == 3) ? 7 : 0;
            recv_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 7 : 0;
            if (ph == 1) hold_cycles = 400;
            for (int i = 0; i < N_RANDOM / 4; i++) send_event(rand_event());
            if (ph == 2) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (sb.pending_mass.size() != 0) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        // Drain the pipeline
        while (sb.pending_mass.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        if (sb.n_bad == 0) begin
            $display("tb_transverse_mass_two_and_four_body_top: clean");
        end else begin
            $display("tb_transverse_mass_two_and_four_body_top: errors");
        end
        $finish;
    end

endmodule
